// ===== sv/bfrp_pkg.sv =====
// Shared types and constants for the random-pad bit framer.
package bfrp_pkg;

  localparam int unsigned FLAG_MAX_BITS   = 64;
  localparam int unsigned PAD_COUNT_WIDTH = 32;

  localparam int unsigned MtN = 312;
  localparam int unsigned MtM = 156;
  localparam int unsigned MtAw = $clog2(MtN);
  localparam logic [63:0] MT_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] MT_UPPER  = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] MT_LOWER  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MT_SEED_MUL = 64'd6364136223846793005;
  localparam logic [31:0] SEED_RESET = 32'd5489;

  localparam int unsigned AddrW = 6;

  typedef enum logic [2:0] {
    REG_START_FLAG     = 3'd0,
    REG_START_FLAG_LEN = 3'd1,
    REG_END_FLAG       = 3'd2,
    REG_END_FLAG_LEN   = 3'd3,
    REG_LEFT_PAD       = 3'd4,
    REG_RIGHT_PAD      = 3'd5,
    REG_SEED           = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_DATA = 2'd0,
    OP_TICK = 2'd1,
    OP_END  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_TRAILER = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEED0, ST_M0, ST_M1, ST_M2, ST_BIT,
    ST_D0, ST_D1, ST_D2, ST_D3, ST_D4, ST_FIN, ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
  } out_t;

  function automatic logic [63:0] mt_temper(logic [63:0] v);
    logic [63:0] x;
    x = v;
    x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
    x = x ^ ((x << 17) & 64'h71D6_7FFF_A604_E000);
    x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
    x = x ^ (x >> 43);
    return x;
  endfunction

endpackage

// ===== sv/bfrp_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bfrp_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 312
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/bit_framer_random_pad.sv =====
// Top level of the random-pad bit framer.
// Builds one frame as an MSB-first byte stream: random left pad, start flag,
// payload bytes at any bit offset, end flag, random right pad, zero fill.
// A payload byte passes through the emit state. A tick works one bit a cycle
// until a byte completes or the section ends; each random byte first takes three
// reads and one write-back of the 312-entry generator table in one RAM.
// The first tick of a frame reseeds that table first, each entry after
// entry 0 through one shared 32x32 multiplier. Input is stalled while an
// item is at work; one finished byte waits in the output register.
module bit_framer_random_pad
  import bfrp_pkg::*;
#(
  parameter int unsigned FlagMaxBits   = FLAG_MAX_BITS,
  parameter int unsigned PadCountWidth = PAD_COUNT_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam logic [6:0] FlagMax = 7'(FlagMaxBits);

  // configuration
  logic [63:0] sflag_q, eflag_q;
  logic [6:0]  slen_q, elen_q;
  logic [31:0] lpad_q, rpad_q, seed_q;
  reg_idx_e    ridx;

  assign ridx   = reg_idx_e'(paddr[AddrW-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sflag_q <= '0;
      eflag_q <= '0;
      slen_q  <= '0;
      elen_q  <= '0;
      lpad_q  <= '0;
      rpad_q  <= '0;
      seed_q  <= SEED_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_START_FLAG:     sflag_q <= pwdata;
        REG_START_FLAG_LEN: slen_q  <= pwdata[6:0];
        REG_END_FLAG:       eflag_q <= pwdata;
        REG_END_FLAG_LEN:   elen_q  <= pwdata[6:0];
        REG_LEFT_PAD:       lpad_q  <= pwdata[31:0];
        REG_RIGHT_PAD:      rpad_q  <= pwdata[31:0];
        REG_SEED:           seed_q  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_START_FLAG:     prdata = sflag_q;
      REG_START_FLAG_LEN: prdata = {57'd0, slen_q};
      REG_END_FLAG:       prdata = eflag_q;
      REG_END_FLAG_LEN:   prdata = {57'd0, elen_q};
      REG_LEFT_PAD:       prdata = {32'd0, lpad_q};
      REG_RIGHT_PAD:      prdata = {32'd0, rpad_q};
      REG_SEED:           prdata = {32'd0, seed_q};
      default:            prdata = '0;
    endcase
  end

  // framer state
  state_e                   state_q, state_d;
  phase_e                   phase_q, phase_d;
  logic                     open_q, open_d;
  logic [7:0]               acc_q, acc_d;
  logic [2:0]               off_q, off_d;
  logic [PadCountWidth-1:0] pad_q, pad_d;
  logic [6:0]               fpos_q, fpos_d;
  logic [MtAw-1:0]          idx_q, idx_d;
  logic [7:0]               rbyte_q, rbyte_d;
  logic [3:0]               rleft_q, rleft_d;
  in_t                      item_q, item_d;
  logic                     done_q, done_d;
  logic [7:0]               byte_q, byte_d;
  logic                     last_q, last_d;
  logic [MtAw-1:0]          sidx_q, sidx_d;
  logic [63:0]              prev_q, prev_d;
  logic [63:0]              macc_q, macc_d;
  logic [63:0]              ta_q, ta_d, tb_q, tb_d, tv_q, tv_d;
  logic                     ovalid_q, ovalid_d;
  out_t                     odata_q, odata_d;

  // table RAM
  logic            we;
  logic [MtAw-1:0] waddr, raddr;
  logic [63:0]     wdata, rdata;

  bfrp_ram #(.Width(64), .Depth(MtN)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, seed_x;
  assign seed_x = prev_q ^ (prev_q >> 62);
  assign mul_p  = 64'(mul_a) * 64'(mul_b);

  // helpers
  logic [6:0]  slen_c, elen_c, flen;
  logic [63:0] flag;
  logic [5:0]  fsh;
  logic [3:0]  rsel;
  logic        hdr, pad_nz, flag_left;
  logic [15:0] shifted;
  logic [63:0] twy, twv;
  logic [MtAw-1:0] idx_p1, idx_pm;

  assign slen_c    = (slen_q > FlagMax) ? FlagMax : slen_q;
  assign elen_c    = (elen_q > FlagMax) ? FlagMax : elen_q;
  assign hdr       = (phase_q == PH_HEADER);
  assign flen      = hdr ? slen_c : elen_c;
  assign flag      = hdr ? sflag_q : eflag_q;
  assign fsh       = 6'(flen - 7'd1 - fpos_q);
  assign rsel      = rleft_q - 4'd1;
  assign pad_nz    = (pad_q != '0);
  assign flag_left = (fpos_q < flen);
  assign shifted   = {item_q.data_byte, 8'd0} >> off_q;
  assign idx_p1    = (idx_q == MtAw'(MtN - 1)) ? '0 : idx_q + MtAw'(1);
  assign idx_pm    = (idx_q < MtAw'(MtM)) ? idx_q + MtAw'(MtM) : idx_q - MtAw'(MtM);
  assign twy       = (ta_q & MT_UPPER) | (tb_q & MT_LOWER);
  assign twv       = rdata ^ (twy >> 1) ^ (twy[0] ? MT_MATRIX : 64'd0);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  always_comb begin
    logic       use_pad, use_flag, bitv, empty;
    logic [7:0] acc_n;
    state_d  = state_q;
    phase_d  = phase_q;
    open_d   = open_q;
    acc_d    = acc_q;
    off_d    = off_q;
    pad_d    = pad_q;
    fpos_d   = fpos_q;
    idx_d    = idx_q;
    rbyte_d  = rbyte_q;
    rleft_d  = rleft_q;
    item_d   = item_q;
    done_d   = done_q;
    byte_d   = byte_q;
    last_d   = last_q;
    sidx_d   = sidx_q;
    prev_d   = prev_q;
    macc_d   = macc_q;
    ta_d     = ta_q;
    tb_d     = tb_q;
    tv_d     = tv_q;
    ovalid_d = ovalid_q && out_stall_i;
    odata_d  = odata_q;
    we       = 1'b0;
    waddr    = sidx_q;
    wdata    = macc_q;
    raddr    = idx_q;
    mul_a    = seed_x[31:0];
    mul_b    = MT_SEED_MUL[31:0];
    use_pad  = 1'b0;
    use_flag = 1'b0;
    bitv     = 1'b0;
    empty    = 1'b0;
    acc_n    = acc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          if (phase_q == PH_PAYLOAD) begin
            if (in_data_i.operation == OP_DATA) begin
              state_d = ST_EMIT;
              last_d  = 1'b0;
            end else if (in_data_i.operation == OP_END) begin
              phase_d = PH_TRAILER;
              pad_d   = PadCountWidth'(rpad_q);
              fpos_d  = '0;
              rleft_d = '0;
            end
          end else if (in_data_i.operation == OP_TICK) begin
            done_d = 1'b0;
            if (hdr && !open_q) begin
              open_d  = 1'b1;
              pad_d   = PadCountWidth'(lpad_q);
              fpos_d  = '0;
              rleft_d = '0;
              state_d = ST_SEED0;
            end else begin
              state_d = ST_BIT;
            end
          end
        end
      end
      ST_SEED0: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = {32'd0, seed_q};
        prev_d  = {32'd0, seed_q};
        sidx_d  = MtAw'(1);
        state_d = ST_M0;
      end
      ST_M0: begin
        macc_d  = mul_p;
        state_d = ST_M1;
      end
      ST_M1: begin
        mul_b   = MT_SEED_MUL[63:32];
        macc_d  = macc_q + {mul_p[31:0], 32'd0};
        state_d = ST_M2;
      end
      ST_M2: begin
        mul_a  = seed_x[63:32];
        we     = 1'b1;
        wdata  = macc_q + {mul_p[31:0], 32'd0} + 64'(sidx_q);
        prev_d = wdata;
        if (sidx_q == MtAw'(MtN - 1)) begin
          idx_d   = '0;
          state_d = ST_BIT;
        end else begin
          sidx_d  = sidx_q + MtAw'(1);
          state_d = ST_M0;
        end
      end
      ST_BIT: begin
        // header: pad then flag; trailer: flag then pad
        if (hdr) begin
          use_pad  = pad_nz;
          use_flag = !pad_nz && flag_left;
        end else begin
          use_flag = flag_left;
          use_pad  = !flag_left && pad_nz;
        end
        if (use_pad && rleft_q == 4'd0) begin
          state_d = ST_D0;
        end else if (use_pad || use_flag) begin
          if (use_pad) begin
            bitv    = rbyte_q[rsel[2:0]];
            rleft_d = rsel;
            pad_d   = pad_q - PadCountWidth'(1);
            if (pad_q == PadCountWidth'(1)) begin
              rleft_d = '0;
            end
          end else begin
            bitv   = flag[fsh];
            fpos_d = fpos_q + 7'd1;
          end
          acc_n = acc_q | (8'(bitv) << (3'd7 - off_q));
          if (off_q == 3'd7) begin
            byte_d  = acc_n;
            done_d  = 1'b1;
            acc_d   = '0;
            off_d   = '0;
            state_d = ST_FIN;
          end else begin
            acc_d = acc_n;
            off_d = off_q + 3'd1;
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_D0: begin
        raddr   = idx_q;
        state_d = ST_D1;
      end
      ST_D1: begin
        raddr   = idx_p1;
        ta_d    = rdata;
        state_d = ST_D2;
      end
      ST_D2: begin
        raddr   = idx_pm;
        tb_d    = rdata;
        state_d = ST_D3;
      end
      ST_D3: begin
        we      = 1'b1;
        waddr   = idx_q;
        wdata   = twv;
        tv_d    = twv;
        state_d = ST_D4;
      end
      ST_D4: begin
        rbyte_d = 8'(mt_temper(tv_q));
        rleft_d = 4'd8;
        idx_d   = idx_p1;
        state_d = ST_BIT;
      end
      ST_FIN: begin
        empty   = !pad_nz && !flag_left;
        last_d  = 1'b0;
        state_d = done_q ? ST_EMIT : ST_IDLE;
        if (hdr) begin
          if (empty) begin
            phase_d = PH_PAYLOAD;
            fpos_d  = '0;
          end
        end else if (empty) begin
          // close the frame, flushing a partial byte with zero fill
          if (!done_q && off_q != 3'd0) begin
            byte_d  = acc_q;
            state_d = ST_EMIT;
          end else if (!done_q) begin
            state_d = ST_IDLE;
          end
          last_d  = 1'b1;
          acc_d   = '0;
          off_d   = '0;
          phase_d = PH_HEADER;
          open_d  = 1'b0;
          fpos_d  = '0;
          rleft_d = '0;
        end
      end
      ST_EMIT: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          if (item_q.operation == OP_DATA) begin
            odata_d.out_byte   = acc_q | shifted[15:8];
            odata_d.frame_last = 1'b0;
            acc_d              = shifted[7:0];
          end else begin
            odata_d.out_byte   = byte_q;
            odata_d.frame_last = last_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_HEADER;
      open_q   <= 1'b0;
      acc_q    <= '0;
      off_q    <= '0;
      pad_q    <= '0;
      fpos_q   <= '0;
      idx_q    <= '0;
      rbyte_q  <= '0;
      rleft_q  <= '0;
      done_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      open_q   <= open_d;
      acc_q    <= acc_d;
      off_q    <= off_d;
      pad_q    <= pad_d;
      fpos_q   <= fpos_d;
      idx_q    <= idx_d;
      rbyte_q  <= rbyte_d;
      rleft_q  <= rleft_d;
      done_q   <= done_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
    sidx_q  <= sidx_d;
    prev_q  <= prev_d;
    macc_q  <= macc_d;
    ta_q    <= ta_d;
    tb_q    <= tb_d;
    tv_q    <= tv_d;
    odata_q <= odata_d;
  end

endmodule

// ===== sv/bfrp_checker.sv =====
// Port-level checks for the random-pad bit framer, bound to the top level.
module bfrp_checker
  import bfrp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_t             out_data_o,
  input logic             pready
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  // a new beat only comes from an item at work
  a_beat_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output beat without an item at work");

  // a closing beat ends the frame: no data beat follows right away
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.frame_last |=> !in_stall_o || !out_valid_o)
    else $error("beat straight after frame end");

endmodule

bind bit_framer_random_pad bfrp_checker u_bfrp_checker (.*);
